// ----- rtl/snrs_pkg.sv -----
package snrs_pkg;

	localparam logic [7:0] OP_PAGE_READ  = 8'h13;
	localparam logic [7:0] OP_READ_CACHE = 8'h03;

	localparam logic [3:0] WRAP_16   = 4'hC;
	localparam logic [3:0] WRAP_64   = 4'h8;
	localparam logic [3:0] WRAP_2048 = 4'h4;

	localparam logic [5:0] CHUNK_LOW   = 6'd16;
	localparam logic [5:0] CHUNK_HIGH  = 6'd60;
	localparam logic [5:0] CHUNK_RESET = 6'd56;
	localparam logic [8:0] LEN_HIGH    = 9'd448;

	localparam logic [6:0] HDR_BYTES = 7'd4;

	localparam logic REG_CHUNK_MAX = 1'b0;

	typedef struct packed {
		logic        inval;
		logic [31:0] addr;
		logic [8:0]  len;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} seq_state_t;

endpackage

// ----- rtl/spi_nand_read_sequencer.sv -----
// channel  | handshake               | payload
// req      | req_valid / req_stall   | kind, start_addr, length
// desc     | desc_valid / desc_stall | opcode, cmd_arg, burst_bytes, rx_bytes,
//          |                         | buffer_offset, last
// cfg      | APB psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// One descriptor per cycle out of the sequencer while desc_stall is low; a read
// of L bytes is one dequeue followed by one descriptor per chunk and per page read.
// Requests wait in a two-entry queue; req_stall is high only while it is full.
// Invalidates are dequeued without a descriptor; zero-length reads are dropped unqueued.
// Reset empties the queue, clears desc_valid and forgets the cached page.
module spi_nand_read_sequencer #(
	parameter int PAGE_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        kind,
	input  logic [31:0] start_addr,
	input  logic [8:0]  length,
	output logic        desc_valid,
	input  logic        desc_stall,
	output logic [7:0]  opcode,
	output logic [23:0] cmd_arg,
	output logic [6:0]  burst_bytes,
	output logic [5:0]  rx_bytes,
	output logic [8:0]  buffer_offset,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0]     chunk_max_q;
	logic [5:0]     cmax;
	logic           queue_full;
	logic           push;
	snrs_pkg::cmd_t push_cmd;
	logic           pop;
	logic           pop_valid;
	snrs_pkg::cmd_t pop_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == snrs_pkg::REG_CHUNK_MAX) ? {26'd0, chunk_max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_max_q <= snrs_pkg::CHUNK_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == snrs_pkg::REG_CHUNK_MAX)) begin
			chunk_max_q <= pwdata[5:0];
		end
	end

	always_comb begin
		if (chunk_max_q < snrs_pkg::CHUNK_LOW) begin
			cmax = snrs_pkg::CHUNK_LOW;
		end else if (chunk_max_q > snrs_pkg::CHUNK_HIGH) begin
			cmax = snrs_pkg::CHUNK_HIGH;
		end else begin
			cmax = chunk_max_q;
		end
	end

	snrs_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.kind       (kind),
		.start_addr (start_addr),
		.length     (length),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	snrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_cmd)
	);

	snrs_back #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd           (pop_cmd),
		.cmd_pop       (pop),
		.cmax          (cmax),
		.desc_valid    (desc_valid),
		.desc_stall    (desc_stall),
		.opcode        (opcode),
		.cmd_arg       (cmd_arg),
		.burst_bytes   (burst_bytes),
		.rx_bytes      (rx_bytes),
		.buffer_offset (buffer_offset),
		.last          (last)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && last |-> opcode == snrs_pkg::OP_READ_CACHE)
	else $error("last flag on a page read");

	assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid |-> burst_bytes == snrs_pkg::HDR_BYTES + 7'(rx_bytes))
	else $error("burst length does not match data length");

	assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && opcode == snrs_pkg::OP_READ_CACHE |-> rx_bytes != 6'd0 && rx_bytes <= cmax)
	else $error("read-from-cache size out of range");

endmodule

// ----- rtl/snrs_front.sv -----
module snrs_front (
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic [31:0]        start_addr,
	input  logic [8:0]         length,
	input  logic               queue_full,
	output logic               push,
	output snrs_pkg::cmd_t     cmd
);

	logic drop;

	// zero-length reads change nothing
	assign drop      = !kind && (length == 9'd0);
	assign req_stall = queue_full;
	assign push      = req_valid && !queue_full && !drop;

	always_comb begin
		cmd.inval = kind;
		cmd.addr  = start_addr;
		cmd.len   = (length > snrs_pkg::LEN_HIGH) ? snrs_pkg::LEN_HIGH : length;
	end

endmodule

// ----- rtl/snrs_queue.sv -----
module snrs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  snrs_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output snrs_pkg::cmd_t pop_data
);

	snrs_pkg::cmd_t entry_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           do_pop;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = entry_q[rd_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/snrs_back.sv -----
module snrs_back #(
	parameter int PAGE_BYTES = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  snrs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [5:0]     cmax,
	output logic           desc_valid,
	input  logic           desc_stall,
	output logic [7:0]     opcode,
	output logic [23:0]    cmd_arg,
	output logic [6:0]     burst_bytes,
	output logic [5:0]     rx_bytes,
	output logic [8:0]     buffer_offset,
	output logic           last
);

	localparam int PG_W = $clog2(PAGE_BYTES);
	localparam int PN_W = 32 - PG_W;

	snrs_pkg::seq_state_t state_q, state_d;

	logic [31:0]     addr_q;
	logic [8:0]      left_q;
	logic [8:0]      off_q;
	logic [5:0]      cmax_q;
	logic [PN_W-1:0] cached_page_q;
	logic            cached_valid_q;

	logic            dv_q;
	logic [7:0]      opcode_q;
	logic [23:0]     arg_q;
	logic [6:0]      burst_q;
	logic [5:0]      rx_q;
	logic [8:0]      boff_q;
	logic            last_q;

	logic [PN_W-1:0] page;
	logic [PG_W-1:0] col;
	logic [11:0]     col_x;
	logic [PG_W:0]   room;
	logic [5:0]      n0;
	logic [5:0]      n;
	logic            miss;
	logic            slot;
	logic            done;
	logic [3:0]      wrap;
	logic            emit_pr;
	logic            emit_rc;

	always_comb begin
		page  = addr_q[31:PG_W];
		col   = addr_q[PG_W-1:0];
		col_x = 12'(col);
		room  = (PG_W+1)'(PAGE_BYTES) - {1'b0, col};
		n0    = (left_q < 9'(cmax_q)) ? 6'(left_q) : cmax_q;
		n     = (room < (PG_W+1)'(n0)) ? 6'(room) : n0;
		miss  = !cached_valid_q || (cached_page_q != page);
		slot  = !dv_q || !desc_stall;
		done  = (left_q == 9'(n));
		if ((7'(col[3:0]) + 7'(n)) <= 7'd16) begin
			wrap = snrs_pkg::WRAP_16;
		end else if ((7'(col_x[5:0]) + 7'(n)) <= 7'd64) begin
			wrap = snrs_pkg::WRAP_64;
		end else begin
			wrap = snrs_pkg::WRAP_2048;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			snrs_pkg::ST_IDLE: begin
				if (cmd_valid && !cmd.inval) begin
					state_d = snrs_pkg::ST_WALK;
				end
			end
			snrs_pkg::ST_WALK: begin
				if (slot && !miss && done) begin
					state_d = snrs_pkg::ST_IDLE;
				end
			end
			default: state_d = snrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		emit_pr = 1'b0;
		emit_rc = 1'b0;
		case (state_q)
			snrs_pkg::ST_IDLE: begin
				cmd_pop = cmd_valid;
			end
			snrs_pkg::ST_WALK: begin
				emit_pr = slot && miss;
				emit_rc = slot && !miss;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= snrs_pkg::ST_IDLE;
			cached_valid_q <= 1'b0;
			cached_page_q  <= '0;
			dv_q           <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop && cmd.inval) begin
				cached_valid_q <= 1'b0;
			end else if (emit_pr) begin
				cached_valid_q <= 1'b1;
				cached_page_q  <= page;
			end
			if (slot) begin
				dv_q <= emit_pr || emit_rc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.inval) begin
			addr_q <= cmd.addr;
			left_q <= cmd.len;
			off_q  <= 9'd0;
			cmax_q <= cmax;
		end else if (emit_rc) begin
			addr_q <= addr_q + 32'(n);
			left_q <= left_q - 9'(n);
			off_q  <= off_q + 9'(n);
		end
		if (emit_pr) begin
			opcode_q <= snrs_pkg::OP_PAGE_READ;
			arg_q    <= 24'(page);
			burst_q  <= snrs_pkg::HDR_BYTES;
			rx_q     <= 6'd0;
			boff_q   <= off_q;
			last_q   <= 1'b0;
		end else if (emit_rc) begin
			opcode_q <= snrs_pkg::OP_READ_CACHE;
			arg_q    <= {wrap, col_x[11:8], col_x[7:0], 8'h00};
			burst_q  <= snrs_pkg::HDR_BYTES + 7'(n);
			rx_q     <= n;
			boff_q   <= off_q;
			last_q   <= done;
		end
	end

	assign desc_valid    = dv_q;
	assign opcode        = opcode_q;
	assign cmd_arg       = arg_q;
	assign burst_bytes   = burst_q;
	assign rx_bytes      = rx_q;
	assign buffer_offset = boff_q;
	assign last          = last_q;

endmodule
